### hdl/chunked_heightmap_triangle_sample_unit_defines.svh
// Assertion macros shared by the heightmap sampler modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CHUNKED_HEIGHTMAP_TRIANGLE_SAMPLE_UNIT_DEFINES_SVH
`define CHUNKED_HEIGHTMAP_TRIANGLE_SAMPLE_UNIT_DEFINES_SVH

// Property checked on every edge outside reset
`define CHTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset
`define CHTS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hdl/chts_pkg.sv
// Types and constants for the chunked heightmap triangle sampler.
// No dependencies; used by every module of the block but chts_ram.
package chts_pkg;

  localparam int COORD_W         = 16;
  localparam int FRAC_W          = 16;
  localparam int CELL_BITS       = 6;
  localparam int CHUNK_CELLS     = 64;
  localparam int CELLS_PER_CHUNK = CHUNK_CELLS * CHUNK_CELLS;
  localparam int SAMPLE_W        = 11;
  localparam int WEIGHT_W        = 17;
  localparam int SLOT_W          = 4;
  localparam int MAX_SLOTS       = 16;
  localparam int CHUNK_IDX_W     = 18;
  localparam int ACC_W           = 28;
  localparam int OUT_SHIFT       = 5;
  localparam int OUT_W           = 22;
  localparam int FULL_ADDR_W     = SLOT_W + 2 * CELL_BITS;

  localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = 17'h10000;

  // Beat counter: three sample reads per query
  localparam logic [1:0] BEAT_FIRST = 2'd0;
  localparam logic [1:0] BEAT_MID   = 2'd1;
  localparam logic [1:0] BEAT_LAST  = 2'd2;

  typedef enum logic [1:0] {
    OP_QUERY      = 2'd0,
    OP_WR_HEIGHT  = 2'd1,
    OP_WR_PRESENT = 2'd2
  } op_t;

  // Sample RAM port control
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Tag that travels with one sample read
  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic                ok;
    logic [WEIGHT_W-1:0] weight;
  } beat_t;

endpackage

### hdl/chts_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module chts_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/chts_issue.sv
// Request register, chunk present bits and sample address generation.
// Depends on chts_pkg and the assertion macro header.
`include "chunked_heightmap_triangle_sample_unit_defines.svh"
module chts_issue #(
  parameter int CHUNK_GRID = 4,
  parameter int ADDR_W     = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [31:0]                    in_world_x,
  input  logic [31:0]                    in_world_z,
  input  logic [3:0]                     in_chunk_slot,
  input  logic [5:0]                     in_cell_col_x,
  input  logic [5:0]                     in_cell_row_z,
  input  logic [10:0]                    in_height_in,
  input  logic                           in_present_in,
  input  logic                           stall,
  output chts_pkg::mem_ctl_t             mem_ctl,
  output logic [ADDR_W-1:0]              mem_addr,
  output logic [chts_pkg::SAMPLE_W-1:0]  mem_wdata,
  output chts_pkg::beat_t                beat
);

  localparam int NUM_CHUNKS  = CHUNK_GRID * CHUNK_GRID;
  localparam int NUM_SLOTS   = (NUM_CHUNKS < chts_pkg::MAX_SLOTS) ? NUM_CHUNKS
                                                                  : chts_pkg::MAX_SLOTS;
  localparam int CW          = chts_pkg::COORD_W;
  localparam int CB          = chts_pkg::CELL_BITS;
  localparam int WW          = chts_pkg::WEIGHT_W;
  localparam int KW          = chts_pkg::CHUNK_IDX_W;

  // Request register
  logic                          busy_r, busy_nxt;
  logic [1:0]                    op_r;
  logic [1:0]                    k_r, k_nxt;
  logic [CW-1:0]                 cx_r, cz_r;
  logic [chts_pkg::FRAC_W-1:0]   fx_r, fz_r;
  logic [chts_pkg::SLOT_W-1:0]   slot_r;
  logic [CB-1:0]                 col_r, row_r;
  logic [chts_pkg::SAMPLE_W-1:0] hin_r;
  logic                          pin_r;
  logic [chts_pkg::MAX_SLOTS-1:0] present_r;

  logic            accept, is_query, issue_last, step;
  logic [WW-1:0]   fsum;
  logic            tri_hi;
  logic            dx, dz;
  logic [WW-1:0]   weight;
  logic [CW:0]     gx, gz;
  logic [KW-1:0]   chunk;
  logic            chunk_ok, slot_ok;
  logic [chts_pkg::FULL_ADDR_W-1:0] rd_addr_full, wr_addr_full;

  assign is_query   = busy_r && (op_r == chts_pkg::OP_QUERY);
  assign issue_last = busy_r && (!is_query || (k_r == chts_pkg::BEAT_LAST));
  assign step       = busy_r && !stall;
  assign in_ready   = !stall && (!busy_r || issue_last);
  assign accept     = in_valid && in_ready;

  // Triangle choice and corner weights
  assign fsum   = {1'b0, fx_r} + {1'b0, fz_r};
  assign tri_hi = fsum[WW-1];

  always_comb begin
    dx     = 1'b0;
    dz     = 1'b0;
    weight = '0;
    case (k_r)
      chts_pkg::BEAT_FIRST: begin
        dx     = tri_hi;
        dz     = tri_hi;
        weight = tri_hi ? {1'b0, fsum[WW-2:0]} : chts_pkg::ONE_WEIGHT - fsum;
      end
      chts_pkg::BEAT_MID: begin
        dx     = !tri_hi;
        dz     = tri_hi;
        weight = tri_hi ? chts_pkg::ONE_WEIGHT - {1'b0, fx_r} : {1'b0, fx_r};
      end
      chts_pkg::BEAT_LAST: begin
        dx     = tri_hi;
        dz     = !tri_hi;
        weight = tri_hi ? chts_pkg::ONE_WEIGHT - {1'b0, fz_r} : {1'b0, fz_r};
      end
      default: begin
        dx     = 1'b0;
        dz     = 1'b0;
        weight = '0;
      end
    endcase
  end

  // Global cell, chunk index and sample address
  assign gx    = {1'b0, cx_r} + (CW+1)'(dx);
  assign gz    = {1'b0, cz_r} + (CW+1)'(dz);
  assign chunk = KW'(gx[CW:CB]) * KW'(CHUNK_GRID) + KW'(gz[CW:CB]);
  assign chunk_ok = (chunk < KW'(NUM_SLOTS)) &&
                    present_r[chunk[chts_pkg::SLOT_W-1:0]];
  assign slot_ok  = ((chts_pkg::SLOT_W+1)'(slot_r) < (chts_pkg::SLOT_W+1)'(NUM_SLOTS));

  assign rd_addr_full = {chunk[chts_pkg::SLOT_W-1:0], gx[CB-1:0], gz[CB-1:0]};
  assign wr_addr_full = {slot_r, col_r, row_r};

  // Memory port and read tag
  always_comb begin
    mem_ctl.re   = step && is_query && chunk_ok;
    mem_ctl.we   = step && (op_r == chts_pkg::OP_WR_HEIGHT) && slot_ok;
    mem_addr     = is_query ? rd_addr_full[ADDR_W-1:0] : wr_addr_full[ADDR_W-1:0];
    mem_wdata    = hin_r;
    beat.vld     = is_query;
    beat.first   = (k_r == chts_pkg::BEAT_FIRST);
    beat.last    = (k_r == chts_pkg::BEAT_LAST);
    beat.ok      = chunk_ok;
    beat.weight  = weight;
  end

  // Busy flag and beat counter
  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (accept) begin
      busy_nxt = 1'b1;
      k_nxt    = chts_pkg::BEAT_FIRST;
    end else if (step) begin
      if (issue_last) begin
        busy_nxt = 1'b0;
      end
      k_nxt = k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      k_r       <= chts_pkg::BEAT_FIRST;
      present_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      if (step && (op_r == chts_pkg::OP_WR_PRESENT) && slot_ok) begin
        present_r[slot_r] <= pin_r;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      cx_r   <= in_world_x[31:16];
      fx_r   <= in_world_x[15:0];
      cz_r   <= in_world_z[31:16];
      fz_r   <= in_world_z[15:0];
      slot_r <= in_chunk_slot;
      col_r  <= in_cell_col_x;
      row_r  <= in_cell_row_z;
      hin_r  <= in_height_in;
      pin_r  <= in_present_in;
    end
  end

  `CHTS_NEVER(a_port_exclusive, mem_ctl.we && mem_ctl.re, "sample RAM read and write together")
  `CHTS_ASSERT(a_query_starts, (accept && (in_opcode == chts_pkg::OP_QUERY)) |=> (is_query && (k_r == chts_pkg::BEAT_FIRST)), "query did not start at first beat")
  `CHTS_NEVER(a_beat_range, busy_r && (k_r == 2'd3), "beat counter past last beat")

endmodule

### hdl/chts_accum.sv
// Weighted accumulation of the three sample reads and the result register.
// Depends on chts_pkg and the assertion macro header.
`include "chunked_heightmap_triangle_sample_unit_defines.svh"
module chts_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chts_pkg::beat_t               beat,
  input  logic [chts_pkg::SAMPLE_W-1:0] rd_data,
  output logic                          stall,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [chts_pkg::OUT_W-1:0]    out_height_out
);

  localparam int AW = chts_pkg::ACC_W;

  chts_pkg::beat_t                tag_r;
  logic [AW-1:0]                  acc_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [chts_pkg::OUT_W-1:0]     out_height_r;
  logic [AW-1:0]                  prod, acc_sum;
  logic                           done;

  // Hold the final beat while the result register is still full
  assign stall = out_valid_r && !out_ready && tag_r.vld && tag_r.last;
  assign done  = tag_r.vld && tag_r.last && !stall;

  // One multiply and add per returning sample
  assign prod    = tag_r.ok ? AW'(rd_data) * AW'(tag_r.weight) : '0;
  assign acc_sum = (tag_r.first ? '0 : acc_r) + prod;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Read tag and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (!stall) begin
        tag_r <= beat;
      end
    end
  end

  // Accumulator and result
  always_ff @(posedge clk) begin
    if (!stall) begin
      if (tag_r.vld) begin
        acc_r <= acc_sum;
      end
    end
    if (done) begin
      out_height_r <= acc_sum[chts_pkg::OUT_SHIFT +: chts_pkg::OUT_W];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_height_out = out_height_r;

  `CHTS_ASSERT(a_done_sets_out, done |=> out_valid_r, "finished query left no result")
  `CHTS_ASSERT(a_stall_holds, stall |=> ($stable(acc_r) && $stable(tag_r.vld)), "accumulator moved during stall")
  `CHTS_NEVER(a_stall_needs_full, stall && !out_valid_r, "stall without pending result")

endmodule

### hdl/chunked_heightmap_triangle_sample_unit.sv
// Top level of the chunked heightmap triangle sampler.
// Depends on chts_pkg, chts_issue, chts_accum and chts_ram.
//
// A height query (opcode 0) reads its three triangle corner samples from one
// single-port sample RAM, one read per cycle unless stalled; height writes
// use that port too, present-bit writes set a register. The result is
// registered once the last sample returns and the output register is free.
// Requests are taken while a result waits, unless a last sample is stalled.
// The sample RAM has no reset: a sample in a present chunk reads garbage
// until written. Present bits reset to zero, so every chunk starts empty.
module chunked_heightmap_triangle_sample_unit #(
  parameter int CHUNK_GRID = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_world_x,
  input  logic [31:0] in_world_z,
  input  logic [3:0]  in_chunk_slot,
  input  logic [5:0]  in_cell_col_x,
  input  logic [5:0]  in_cell_row_z,
  input  logic [10:0] in_height_in,
  input  logic        in_present_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [21:0] out_height_out
);

  localparam int NUM_CHUNKS  = CHUNK_GRID * CHUNK_GRID;
  localparam int NUM_SLOTS   = (NUM_CHUNKS < chts_pkg::MAX_SLOTS) ? NUM_CHUNKS
                                                                  : chts_pkg::MAX_SLOTS;
  localparam int STORE_DEPTH = NUM_SLOTS * chts_pkg::CELLS_PER_CHUNK;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  chts_pkg::mem_ctl_t            mem_ctl;
  logic [ADDR_W-1:0]             mem_addr;
  logic [chts_pkg::SAMPLE_W-1:0] mem_wdata, mem_rdata;
  chts_pkg::beat_t               beat;
  logic                          stall;

  chts_issue #(
    .CHUNK_GRID(CHUNK_GRID),
    .ADDR_W    (ADDR_W)
  ) u_issue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_world_x   (in_world_x),
    .in_world_z   (in_world_z),
    .in_chunk_slot(in_chunk_slot),
    .in_cell_col_x(in_cell_col_x),
    .in_cell_row_z(in_cell_row_z),
    .in_height_in (in_height_in),
    .in_present_in(in_present_in),
    .stall        (stall),
    .mem_ctl      (mem_ctl),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .beat         (beat)
  );

  chts_ram #(
    .WIDTH(chts_pkg::SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_sample_ram (
    .clk  (clk),
    .we   (mem_ctl.we),
    .re   (mem_ctl.re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  chts_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat          (beat),
    .rd_data       (mem_rdata),
    .stall         (stall),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_height_out(out_height_out)
  );

endmodule

### dv/chunked_heightmap_triangle_sample_unit_tb.sv
// Self-checking testbench for the chunked heightmap triangle sampler.
// Needs chts_pkg and the chunked_heightmap_triangle_sample_unit RTL; drives height queries
// and map writes, predicts every query height and checks it against the result port.
module chunked_heightmap_triangle_sample_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHUNK_CELLS     = chts_pkg::CHUNK_CELLS;
  localparam int CELLS_PER_CHUNK = chts_pkg::CELLS_PER_CHUNK;
  localparam int GRID        = 4;
  localparam int NUM_CHUNKS  = GRID * GRID;
  localparam int MAP_DEPTH   = NUM_CHUNKS * CELLS_PER_CHUNK;
  localparam int GRID_CELLS  = GRID * CHUNK_CELLS;
  localparam longint UNIT_W  = 65536;
  localparam int RAND_ITEMS  = 900;
  localparam int DRAIN_AT    = 600;
  localparam int HOLD_AFTER  = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_TAIL   = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MAX   = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One request as it goes onto the input port; drain holds it until results are in
  typedef struct packed {
    logic        drain;
    logic [1:0]  opcode;
    logic [31:0] wx;
    logic [31:0] wz;
    logic [3:0]  slot;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [10:0] hgt;
    logic        pres;
  } hm_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_world_x = '0;
  logic [31:0] in_world_z = '0;
  logic [3:0]  in_chunk_slot = '0;
  logic [5:0]  in_cell_col_x = '0;
  logic [5:0]  in_cell_row_z = '0;
  logic [10:0] in_height_in = '0;
  logic        in_present_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [21:0] out_height_out;

  chunked_heightmap_triangle_sample_unit #(
    .CHUNK_GRID(GRID)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_world_x    (in_world_x),
    .in_world_z    (in_world_z),
    .in_chunk_slot (in_chunk_slot),
    .in_cell_col_x (in_cell_col_x),
    .in_cell_row_z (in_cell_row_z),
    .in_height_in  (in_height_in),
    .in_present_in (in_present_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_height_out(out_height_out)
  );

  always #1 clk = ~clk;

  // Request stream and the map view used while building it
  hm_req_t     req_q[$];
  bit          gen_present [NUM_CHUNKS];
  bit          gen_written [MAP_DEPTH];
  int          gen_count = 0;
  bit          drain_marked = 1'b0;

  // Predicted map contents and pending query heights
  bit          map_present [NUM_CHUNKS];
  logic [10:0] map_height [MAP_DEPTH];
  logic [21:0] height_exp_q[$];

  hm_req_t     cur_req;
  int          gap_left = 0;
  int          gap_pct = 0;
  int          sent_cnt = 0;
  int          stall_left = 0;
  int          stall_pct = 0;
  int          heights_seen = 0;
  int          fail_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;
  int          calm_start = 0;
  int          cycle_cnt = 0;

  function automatic int chunk_of(int cx, int cz);
    return (cx >> 6) * GRID + (cz >> 6);
  endfunction

  function automatic int cell_addr(int chunk, int cx, int cz);
    return chunk * CELLS_PER_CHUNK + (cx & (CHUNK_CELLS - 1)) * CHUNK_CELLS
         + (cz & (CHUNK_CELLS - 1));
  endfunction

  // Sample seen by a query: zero past the last chunk index or in an absent chunk
  function automatic longint corner_height(int cx, int cz);
    int ch;
    ch = chunk_of(cx, cz);
    if (ch >= NUM_CHUNKS || !map_present[ch]) return 0;
    return longint'(map_height[cell_addr(ch, cx, cz)]);
  endfunction

  // Split-triangle blend of the three corners, scaled by 65536 then divided by 32
  function automatic logic [21:0] blend_height(logic [31:0] wx, logic [31:0] wz);
    longint fx, fz, ha, hb, hc, acc;
    int     cx, cz;
    fx = longint'(wx[15:0]);
    fz = longint'(wz[15:0]);
    cx = int'(wx[31:16]);
    cz = int'(wz[31:16]);
    hb = corner_height(cx + 1, cz);
    hc = corner_height(cx, cz + 1);
    if (fx + fz < UNIT_W) begin
      ha  = corner_height(cx, cz);
      acc = ha * UNIT_W + fx * (hb - ha) + fz * (hc - ha);
    end else begin
      ha  = corner_height(cx + 1, cz + 1);
      acc = ha * UNIT_W + (UNIT_W - fx) * (hc - ha) + (UNIT_W - fz) * (hb - ha);
    end
    return 22'(acc / 32);
  endfunction

  // Update the predicted map, or queue the height a query must return
  task automatic apply_request(hm_req_t r);
    case (r.opcode)
      chts_pkg::OP_QUERY:      height_exp_q.push_back(blend_height(r.wx, r.wz));
      chts_pkg::OP_WR_HEIGHT:
        map_height[r.slot * CELLS_PER_CHUNK + r.col * CHUNK_CELLS + r.row] = r.hgt;
      chts_pkg::OP_WR_PRESENT: map_present[r.slot] = r.pres;
      default: ;
    endcase
  endtask

  // Fields a request does not use still carry random values
  function automatic hm_req_t rand_req(logic [1:0] op);
    hm_req_t r;
    r.drain  = 1'b0;
    r.opcode = op;
    r.wx     = $urandom;
    r.wz     = $urandom;
    r.slot   = 4'($urandom);
    r.col    = 6'($urandom);
    r.row    = 6'($urandom);
    r.hgt    = 11'($urandom);
    r.pres   = 1'($urandom);
    return r;
  endfunction

  function automatic logic [10:0] rand_height();
    case ($urandom_range(0, 7))
      0:       return 11'h000;
      1:       return 11'h7ff;
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Cells at chunk borders or in a small area near each chunk origin
  function automatic int edge_coord();
    int base;
    base = $urandom_range(0, GRID - 1) * CHUNK_CELLS;
    case ($urandom_range(0, 3))
      0:       return base;
      1:       return base + CHUNK_CELLS - 1;
      default: return base + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic push_req(hm_req_t r);
    if (r.opcode != OP_UNUSED) begin
      if (gen_count == DRAIN_AT && !drain_marked) begin
        r.drain = 1'b1;
        drain_marked = 1'b1;
      end
      gen_count++;
    end
    req_q.push_back(r);
  endtask

  task automatic push_height(int slot, int col, int row, logic [10:0] h);
    hm_req_t r;
    r = rand_req(chts_pkg::OP_WR_HEIGHT);
    r.slot = 4'(slot);
    r.col  = 6'(col);
    r.row  = 6'(row);
    r.hgt  = h;
    gen_written[slot * CELLS_PER_CHUNK + col * CHUNK_CELLS + row] = 1'b1;
    push_req(r);
  endtask

  task automatic push_present(int slot, bit p);
    hm_req_t r;
    r = rand_req(chts_pkg::OP_WR_PRESENT);
    r.slot = 4'(slot);
    r.pres = p;
    gen_present[slot] = p;
    push_req(r);
  endtask

  // A corner in a loaded chunk must hold a written sample before it is read
  task automatic cover_corner(int cx, int cz);
    int ch;
    ch = chunk_of(cx, cz);
    if (ch < NUM_CHUNKS && gen_present[ch] && !gen_written[cell_addr(ch, cx, cz)])
      push_height(ch, cx & (CHUNK_CELLS - 1), cz & (CHUNK_CELLS - 1), rand_height());
  endtask

  task automatic push_query(logic [31:0] wx, logic [31:0] wz);
    hm_req_t r;
    int      cx, cz;
    cx = int'(wx[31:16]);
    cz = int'(wz[31:16]);
    if (int'(wx[15:0]) + int'(wz[15:0]) < UNIT_W) cover_corner(cx, cz);
    else cover_corner(cx + 1, cz + 1);
    cover_corner(cx + 1, cz);
    cover_corner(cx, cz + 1);
    r = rand_req(chts_pkg::OP_QUERY);
    r.wx = wx;
    r.wz = wz;
    push_req(r);
  endtask

  task automatic build_stimulus();
    int          target, pick, cx, cz, ch;
    logic [15:0] fx, fz;
    // directed: extremes of fractions and samples, grid edges, absent chunks, z aliasing
    push_present(0, 1'b1);
    push_present(1, 1'b1);
    push_present(4, 1'b1);
    push_present(15, 1'b1);
    push_height(0, 0, 0, 11'h7ff);
    push_height(0, 1, 0, 11'h000);
    push_height(0, 0, 1, 11'h7ff);
    push_height(0, 1, 1, 11'h000);
    push_query(32'h0000_0000, 32'h0000_0000);
    push_query(32'h0000_ffff, 32'h0000_0000);
    push_query(32'h0000_8000, 32'h0000_7fff);   // fractions sum to just below one: lower triangle
    push_query(32'h0000_8000, 32'h0000_8000);   // fractions sum to one: upper triangle
    push_query(32'h0000_ffff, 32'h0000_ffff);
    push_query(32'h003f_4000, 32'h003f_c000);   // corners in four chunks, one absent
    push_query(32'hffff_ffff, 32'hffff_ffff);   // far outside the grid
    push_query(32'h0005_1234, 32'h0085_4321);   // chunk not loaded
    push_query(32'h000a_2000, 32'h0105_3000);   // z chunk index past the row aliases
    push_query(32'h00ff_9000, 32'h00ff_9000);   // last cell, neighbors off the grid
    push_req(rand_req(OP_UNUSED));
    push_present(1, 1'b0);
    push_query(32'h003f_4000, 32'h003f_c000);   // same spot with one chunk unloaded

    // random: mostly well-formed queries around chunk borders, plus writes and noise
    target = gen_count + RAND_ITEMS;
    while (gen_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        fx = rand_frac();
        case ($urandom_range(0, 9))
          0:       fz = 16'(17'h10000 - fx);
          1:       fz = 16'hffff - fx;
          default: fz = rand_frac();
        endcase
        push_query({16'(edge_coord()), fx}, {16'(edge_coord()), fz});
      end else if (pick < 63) begin
        push_query($urandom, $urandom);
      end else if (pick < 72) begin
        cx = $urandom_range(0, GRID_CELLS - 1);
        cz = $urandom_range(GRID_CELLS, 1023);
        push_query({16'(cx), rand_frac()}, {16'(cz), rand_frac()});
      end else if (pick < 76) begin
        case ($urandom_range(0, 3))
          0:       cx = GRID_CELLS - 1;
          1:       cx = GRID_CELLS;
          2:       cx = 65535;
          default: cx = $urandom_range(0, 65535);
        endcase
        push_query({16'(cx), rand_frac()}, {16'($urandom_range(0, 65535)), rand_frac()});
      end else if (pick < 86) begin
        if ($urandom_range(0, 1)) begin
          cx = edge_coord();
          cz = edge_coord();
          ch = chunk_of(cx, cz);
          push_height(ch, cx & (CHUNK_CELLS - 1), cz & (CHUNK_CELLS - 1), rand_height());
        end else begin
          push_height($urandom_range(0, NUM_CHUNKS - 1), $urandom_range(0, 63),
                      $urandom_range(0, 63), rand_height());
        end
      end else if (pick < 93) begin
        push_present($urandom_range(0, NUM_CHUNKS - 1), $urandom_range(0, 9) < 7);
      end else begin
        push_req(rand_req(OP_UNUSED));
      end
    end
  endtask

  // Result check against the oldest predicted height
  task automatic check_height(logic [21:0] got);
    logic [21:0] want;
    if (height_exp_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= SHOWN_MAX)
        $display("unexpected height result %0d at cycle %0d", got, cycle_cnt);
    end else begin
      want = height_exp_q.pop_front();
      if (got !== want) begin
        fail_cnt++;
        if (fail_cnt <= SHOWN_MAX)
          $display("height mismatch on result %0d: expected %0d, got %0d",
                   heights_seen, want, got);
      end
    end
    heights_seen++;
  endtask

  // Request driver: random gap bursts, pauses at the drain marker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_opcode     <= '0;
      in_world_x    <= '0;
      in_world_z    <= '0;
      in_chunk_slot <= '0;
      in_cell_col_x <= '0;
      in_cell_row_z <= '0;
      in_height_in  <= '0;
      in_present_in <= 1'b0;
      gap_left = 0;
      gap_pct  = 0;
      sent_cnt = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(cur_req);
        sent_cnt++;
        if (sent_cnt % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 50;
          endcase
        end
      end
      calm <= (sent_cnt >= calm_start);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].drain && height_exp_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          in_valid      <= 1'b1;
          in_opcode     <= cur_req.opcode;
          in_world_x    <= cur_req.wx;
          in_world_z    <= cur_req.wz;
          in_chunk_slot <= cur_req.slot;
          in_cell_col_x <= cur_req.col;
          in_cell_row_z <= cur_req.row;
          in_height_in  <= cur_req.hgt;
          in_present_in <= cur_req.pres;
          if (!calm && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && heights_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      stall_pct  = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_height(out_height_out);
        if (heights_seen % 48 == 0) begin
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            default: stall_pct = 40;
          endcase
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    calm_start = req_q.size() - CALM_TAIL;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (req_q.size() != 0 || in_valid || height_exp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_cnt == 0 && height_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
